FILE: design/imr_pkg.sv
// Shared types, constants and helper functions of the inverse-map RGB rotator.
`default_nettype none
package imr_pkg;

	localparam int COORD_W = 6;
	localparam int CHAN_W = 8;
	localparam int PIX_W = 3 * CHAN_W;
	localparam int DIM_W = 7;
	localparam int COEF_W = 8;
	localparam int OFS_W = 8;
	localparam int PROD_W = 16;
	localparam int MAG_W = 13;
	localparam int SHIFT = 20;
	localparam int RECIP_W = SHIFT + 1;
	localparam int QPROD_W = MAG_W + RECIP_W;
	localparam int SUM_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int RECIP_N = 2 ** DIM_W;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_COS    = 2'd2,
		REG_SIN    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                is_render;
		logic                load_ok;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [PIX_W-1:0]    pix;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
		logic signed [COEF_W-1:0] cos_coef;
		logic signed [COEF_W-1:0] sin_coef;
	} cfg_t;

	// Magnitude of a product; products never exceed 8064 in magnitude.
	function automatic logic [MAG_W-1:0] mag_of(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] a;
		a = p[PROD_W-1] ? -p : p;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] apply_sign(input logic [MAG_W-1:0] q,
			input logic neg);
		logic signed [SUM_W-1:0] v;
		v = $signed(SUM_W'(q));
		return neg ? -v : v;
	endfunction

endpackage
`default_nettype wire

FILE: design/imr_front.sv
// Front end: accepts input transfers, classifies them and pushes them into the queue.
`default_nettype none
module imr_front #(
	parameter int MAX_DIM = 64
) (
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        op,
	input  wire logic [imr_pkg::COORD_W-1:0] col,
	input  wire logic [imr_pkg::COORD_W-1:0] row,
	input  wire logic [imr_pkg::CHAN_W-1:0]  red_in,
	input  wire logic [imr_pkg::CHAN_W-1:0]  green_in,
	input  wire logic [imr_pkg::CHAN_W-1:0]  blue_in,
	input  wire logic                        queue_full,
	output logic                             push,
	output imr_pkg::item_t                   push_item
);
	import imr_pkg::*;

	assign in_ready = !queue_full;
	assign push = in_valid && in_ready;

	always_comb begin
		push_item.is_render = op;
		// A load outside the frame store is dropped at the memory stage.
		push_item.load_ok = (32'(col) < MAX_DIM) && (32'(row) < MAX_DIM);
		push_item.col = col;
		push_item.row = row;
		push_item.pix = {red_in, green_in, blue_in};
	end

endmodule
`default_nettype wire

FILE: design/imr_queue.sv
// Short queue of classified items between the front end and the mapping pipeline.
`default_nettype none
module imr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire imr_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output imr_pkg::item_t      head_item
);
	import imr_pkg::*;

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/imr_back.sv
// Mapping pipeline: centring, rotation products, reciprocal division, bounds check, frame store.
`default_nettype none
module imr_back #(
	parameter int MAX_DIM = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire imr_pkg::cfg_t              cfg,
	input  wire logic                       head_valid,
	input  wire imr_pkg::item_t             head_item,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [imr_pkg::CHAN_W-1:0]      red_out,
	output logic [imr_pkg::CHAN_W-1:0]      green_out,
	output logic [imr_pkg::CHAN_W-1:0]      blue_out,
	output logic                            inside_res
);
	import imr_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	// Reciprocal table: floor(n * ceil(2^SHIFT / d) / 2^SHIFT) equals floor(n / d)
	// for every n below 2^MAG_W and every nonzero d below 2^DIM_W.
	logic [RECIP_W-1:0] recip_tab [RECIP_N];
	assign recip_tab[0] = '0;
	for (genvar gi = 1; gi < RECIP_N; gi++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV = RECIP_W'(((2 ** SHIFT) + gi - 1) / gi);
		assign recip_tab[gi] = RV;
	end

	logic [RECIP_W-1:0] recip_w_q;
	logic [RECIP_W-1:0] recip_h_q;

	always_ff @(posedge clk) begin
		recip_w_q <= recip_tab[cfg.width];
		recip_h_q <= recip_tab[cfg.height];
	end

	logic [DIM_W-2:0] w_half;
	logic [DIM_W-2:0] h_half;
	assign w_half = cfg.width[DIM_W-1:1];
	assign h_half = cfg.height[DIM_W-1:1];

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	item_t item_s1, item_s2, item_s3, item_s4;

	assign adv = !valid_s6 || out_ready;
	assign pop = adv && head_valid;

	// Stage 1: centre the destination coordinates.
	logic signed [OFS_W-1:0] cx_s1, cy_s1;

	// Stage 2: the four rotation products as magnitude and sign.
	logic signed [PROD_W-1:0] pa, pb, pc, pd;
	logic [MAG_W-1:0] ma_s2, mb_s2, mc_s2, md_s2;
	logic [3:0]       neg_s2;

	assign pa = PROD_W'(cx_s1) * PROD_W'(cfg.cos_coef);
	assign pb = PROD_W'(cy_s1) * PROD_W'(cfg.sin_coef);
	assign pc = PROD_W'(cx_s1) * PROD_W'(cfg.sin_coef);
	assign pd = PROD_W'(cy_s1) * PROD_W'(cfg.cos_coef);

	// Stage 3: truncating division by multiplication with the reciprocal.
	logic [QPROD_W-1:0] qpa, qpb, qpc, qpd;
	logic [MAG_W-1:0]   qa_s3, qb_s3, qc_s3, qd_s3;
	logic [3:0]         neg_s3;

	assign qpa = QPROD_W'(ma_s2) * QPROD_W'(recip_w_q);
	assign qpb = QPROD_W'(mb_s2) * QPROD_W'(recip_h_q);
	assign qpc = QPROD_W'(mc_s2) * QPROD_W'(recip_w_q);
	assign qpd = QPROD_W'(md_s2) * QPROD_W'(recip_h_q);

	// Stage 4: signed sums and re-centring.
	logic signed [SUM_W-1:0] sx_s4, sy_s4;

	// Stage 5: bounds check and store address.
	logic               inside_s5;
	logic               is_render_s5;
	logic               wr_en_s5;
	logic [ADDR_W-1:0]  addr_s5;
	logic [PIX_W-1:0]   pix_s5;
	logic               sx_ok, sy_ok;

	assign sx_ok = !sx_s4[SUM_W-1] && (sx_s4 < $signed(SUM_W'(cfg.width)));
	assign sy_ok = !sy_s4[SUM_W-1] && (sy_s4 < $signed(SUM_W'(cfg.height)));

	// Stage 6: frame store access.
	logic [PIX_W-1:0] frame_mem [DEPTH];
	logic [PIX_W-1:0] rd_s6;
	logic             inside_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= head_item;
			cx_s1 <= $signed({2'b00, head_item.col}) - $signed({2'b00, w_half});
			cy_s1 <= $signed({2'b00, head_item.row}) - $signed({2'b00, h_half});

			item_s2 <= item_s1;
			ma_s2 <= mag_of(pa);
			mb_s2 <= mag_of(pb);
			mc_s2 <= mag_of(pc);
			md_s2 <= mag_of(pd);
			neg_s2 <= {pd[PROD_W-1], pc[PROD_W-1], pb[PROD_W-1], pa[PROD_W-1]};

			item_s3 <= item_s2;
			qa_s3 <= qpa[SHIFT+MAG_W-1:SHIFT];
			qb_s3 <= qpb[SHIFT+MAG_W-1:SHIFT];
			qc_s3 <= qpc[SHIFT+MAG_W-1:SHIFT];
			qd_s3 <= qpd[SHIFT+MAG_W-1:SHIFT];
			neg_s3 <= neg_s2;

			item_s4 <= item_s3;
			sx_s4 <= apply_sign(qa_s3, neg_s3[0]) - apply_sign(qb_s3, neg_s3[1])
				+ $signed(SUM_W'(w_half));
			sy_s4 <= apply_sign(qc_s3, neg_s3[2]) + apply_sign(qd_s3, neg_s3[3])
				+ $signed(SUM_W'(h_half));

			is_render_s5 <= item_s4.is_render;
			pix_s5 <= item_s4.pix;
			inside_s5 <= sx_ok && sy_ok;
			wr_en_s5 <= valid_s4 && !item_s4.is_render && item_s4.load_ok;
			if (item_s4.is_render) begin
				addr_s5 <= ADDR_W'(32'(sy_s4[DIM_W-1:0]) * MAX_DIM
					+ 32'(sx_s4[DIM_W-1:0]));
			end else begin
				addr_s5 <= ADDR_W'(32'(item_s4.row) * MAX_DIM + 32'(item_s4.col));
			end

			if (wr_en_s5) begin
				frame_mem[addr_s5] <= pix_s5;
			end
			rd_s6 <= frame_mem[addr_s5];
			inside_s6 <= inside_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			// Loads end at the store; only renders leave a result.
			valid_s6 <= valid_s5 && is_render_s5;
		end
	end

	assign out_valid = valid_s6;
	assign inside_res = inside_s6;
	assign red_out = inside_s6 ? rd_s6[PIX_W-1:2*CHAN_W] : '0;
	assign green_out = inside_s6 ? rd_s6[2*CHAN_W-1:CHAN_W] : '0;
	assign blue_out = inside_s6 ? rd_s6[CHAN_W-1:0] : '0;

endmodule
`default_nettype wire

FILE: design/inverse_map_rgb_rotator_unit.sv
// A render result goes through the queue and then each pipeline stage before it is offered.
// Throughput: one item per cycle, loads and renders alike, while the output is not stalled;
// the frame store has one port and serves one item per cycle in the memory stage.
// A four-entry queue lets the input keep taking transfers while a result waits.
// Reset clears handshake state and sets the registers to their defaults; the frame
// store is not cleared and holds undefined pixels until loaded.
`default_nettype none
module inverse_map_rgb_rotator_unit #(
	parameter int MAX_DIM = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [imr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [imr_pkg::PDATA_W-1:0] pwdata,
	output logic [imr_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        op,
	input  wire logic [imr_pkg::COORD_W-1:0] col,
	input  wire logic [imr_pkg::COORD_W-1:0] row,
	input  wire logic [imr_pkg::CHAN_W-1:0]  red_in,
	input  wire logic [imr_pkg::CHAN_W-1:0]  green_in,
	input  wire logic [imr_pkg::CHAN_W-1:0]  blue_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [imr_pkg::CHAN_W-1:0]       red_out,
	output logic [imr_pkg::CHAN_W-1:0]       green_out,
	output logic [imr_pkg::CHAN_W-1:0]       blue_out,
	output logic                             inside_res
);
	import imr_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [COEF_W-1:0] cos_q;
	logic [COEF_W-1:0] sin_q;
	reg_idx_t          reg_idx;
	logic              wr_en;
	cfg_t              cfg;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(64);
			height_q <= DIM_W'(64);
			cos_q <= COEF_W'(64);
			sin_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_COS:    cos_q <= pwdata[COEF_W-1:0];
				REG_SIN:    sin_q <= pwdata[COEF_W-1:0];
				default:    width_q <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_COS:    prdata = PDATA_W'(cos_q);
			REG_SIN:    prdata = PDATA_W'(sin_q);
			default:    prdata = '0;
		endcase
	end

	// A zero dimension counts as one and anything above the store size is clamped.
	always_comb begin
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (32'(width_q) > MAX_DIM) begin
			cfg.width = DIM_W'(MAX_DIM);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (32'(height_q) > MAX_DIM) begin
			cfg.height = DIM_W'(MAX_DIM);
		end else begin
			cfg.height = height_q;
		end
		cfg.cos_coef = $signed(cos_q);
		cfg.sin_coef = $signed(sin_q);
	end

	logic  queue_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	imr_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.col       (col),
		.row       (row),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.queue_full(queue_full),
		.push      (push),
		.push_item (push_item)
	);

	imr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	imr_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.inside_res(inside_res)
	);

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the inverse-map RGB rotator unit.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import imr_pkg::*;

	localparam int FRAME_DIM = 64;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic op;
	logic [COORD_W-1:0] col, row;
	logic [CHAN_W-1:0] red_in, green_in, blue_in;
	logic out_valid, out_ready;
	logic [CHAN_W-1:0] red_out, green_out, blue_out;
	logic inside_res;

	inverse_map_rgb_rotator_unit #(.MAX_DIM(FRAME_DIM)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .col(col), .row(row),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.inside_res(inside_res)
	);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              in_frame;
	} pixel_res_t;

	// Predictor state
	logic [PIX_W-1:0] frame_copy [FRAME_DIM*FRAME_DIM];
	bit               frame_loaded [FRAME_DIM*FRAME_DIM];
	logic [DIM_W-1:0] cfg_width, cfg_height;
	logic [COEF_W-1:0] cfg_cos, cfg_sin;

	pixel_res_t expected_pixels [$];
	int n_errors, n_renders, n_loads, n_inside, n_configs;
	logic [7:0] level_long;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > FRAME_DIM) return FRAME_DIM;
		return int'(v);
	endfunction

	// Source point that a destination pixel maps back to; C-style truncating division.
	function automatic void map_back(input int dc, input int dr, output int sx, output int sy);
		int w, h, c, s, cx, cy;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		c = $signed(cfg_cos);
		s = $signed(cfg_sin);
		cx = dc - w / 2;
		cy = dr - h / 2;
		sx = cx * c / w - cy * s / h + w / 2;
		sy = cx * s / w + cy * c / h + h / 2;
	endfunction

	function automatic bit maps_inside(input int sx, input int sy);
		return sx >= 0 && sx < eff_dim(cfg_width) && sy >= 0 && sy < eff_dim(cfg_height);
	endfunction

	// A render is only safe to send where it would not read an unloaded entry.
	function automatic bit render_safe(input int dc, input int dr);
		int sx, sy;
		map_back(dc, dr, sx, sy);
		if (!maps_inside(sx, sy)) return 1;
		return frame_loaded[sy * FRAME_DIM + sx];
	endfunction

	function automatic pixel_res_t predict_render(input int dc, input int dr);
		int sx, sy;
		pixel_res_t r;
		map_back(dc, dr, sx, sy);
		r = '0;
		if (maps_inside(sx, sy)) begin
			{r.red, r.green, r.blue} = frame_copy[sy * FRAME_DIM + sx];
			r.in_frame = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		n_errors++;
	endtask

	task automatic random_gap(input int max_long);
		int n;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, max_long) : $urandom_range(1, 2);
		repeat (n) @(negedge clk);
	endtask

	// Drops the input valid if the last transfer left it standing; the caller is at a
	// falling edge.
	task automatic stop_input();
		if (in_valid) in_valid <= 1'b0;
	endtask

	// Sends one item; the caller is at a falling edge. Valid is left high when the next
	// item follows straight away.
	task automatic send_item(input logic o, input int c, input int r, input logic [PIX_W-1:0] p);
		in_valid <= 1'b1;
		op <= o;
		col <= c[COORD_W-1:0];
		row <= r[COORD_W-1:0];
		{red_in, green_in, blue_in} <= p;
		do @(posedge clk); while (!in_ready);
		if (o) begin
			expected_pixels.push_back(predict_render(c, r));
			n_renders++;
		end else begin
			frame_copy[r * FRAME_DIM + c] = p;
			frame_loaded[r * FRAME_DIM + c] = 1;
			n_loads++;
		end
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			random_gap(30);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		case (idx)
			REG_WIDTH:  cfg_width = v[DIM_W-1:0];
			REG_HEIGHT: cfg_height = v[DIM_W-1:0];
			REG_COS:    cfg_cos = v[COEF_W-1:0];
			REG_SIN:    cfg_sin = v[COEF_W-1:0];
		endcase
		n_configs++;
	endtask

	task automatic wait_drained();
		stop_input();
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_config(input int w, input int h, input int c, input int s);
		wait_drained();
		write_reg(REG_WIDTH, PDATA_W'(w));
		write_reg(REG_HEIGHT, PDATA_W'(h));
		write_reg(REG_COS, PDATA_W'(c));
		write_reg(REG_SIN, PDATA_W'(s));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Renders a random destination, skipped where it would read an unloaded entry.
	task automatic send_random_render();
		int c, r;
		c = $urandom_range(0, 63);
		r = $urandom_range(0, 63);
		if (render_safe(c, r)) send_item(1'b1, c, r, PIX_W'($urandom));
	endtask

	task automatic test_fill_frame();
		for (int r = 0; r < FRAME_DIM; r++)
			for (int c = 0; c < FRAME_DIM; c++)
				if ((r * FRAME_DIM + c) % 5 == 0 || r == 0 || r == 63 || c == 0 || c == 63)
					send_item(1'b0, c, r, PIX_W'($urandom));
	endtask

	task automatic test_directed();
		send_item(1'b0, 0, 0, 24'hFFFFFF);
		send_item(1'b0, 63, 63, 24'h000000);
		send_item(1'b0, 32, 32, 24'hA5C35A);
		send_item(1'b0, 31, 31, 24'h5A3CA5);
		send_item(1'b1, 32, 32, 24'h0);
		send_item(1'b1, 0, 0, 24'hFFFFFF);
		send_item(1'b1, 63, 63, 24'h0);
		send_item(1'b1, 0, 63, 24'h0);
		send_item(1'b1, 63, 0, 24'h0);
		// Zero size is taken as one and oversized as the maximum.
		set_config(0, 127, 64, 0);
		send_item(1'b1, 0, 0, 24'h0);
		send_item(1'b1, 0, 32, 24'h0);
		send_item(1'b1, 63, 63, 24'h0);
		// Coefficients at the ends of the 8-bit range.
		set_config(64, 64, 127, -128);
		send_item(1'b1, 0, 0, 24'h0);
		send_item(1'b1, 63, 63, 24'h0);
		set_config(64, 64, -64, 64);
		send_item(1'b1, 0, 0, 24'h0);
		send_item(1'b1, 40, 10, 24'h0);
		set_config(1, 1, 0, 0);
		send_item(1'b1, 63, 0, 24'h0);
		send_item(1'b1, 0, 0, 24'h0);
	endtask

	task automatic test_random_phase(input int w, input int h, input int c, input int s,
			input int n_items);
		set_config(w, h, c, s);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_item(1'b0, $urandom_range(0, 63), $urandom_range(0, 63), PIX_W'($urandom));
			else
				send_random_render();
		end
	endtask

	task automatic test_random_settings();
		int w, h;
		test_random_phase(64, 64, 64, 0, 150);
		test_random_phase(64, 64, 0, 64, 150);
		test_random_phase(64, 64, -64, -64, 150);
		test_random_phase(1, 1, -128, 127, 100);
		for (int k = 0; k < 8; k++) begin
			w = $urandom_range(0, 127);
			h = $urandom_range(0, 127);
			test_random_phase(w, h, $urandom_range(0, 255), $urandom_range(0, 255), 110);
		end
	endtask

	// The sender holds off until every render result has been returned.
	task automatic test_hold_off();
		for (int i = 0; i < 20; i++) send_random_render();
		stop_input();
		while (expected_pixels.size() != 0) @(negedge clk);
		for (int i = 0; i < 20; i++) send_random_render();
	endtask

	// Receiver: random stalls, long stretches with none.
	initial begin
		out_ready = 1'b0;
		level_long = 8'd0;
		forever begin
			@(negedge clk);
			if (level_long != 0) begin
				level_long--;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 40) == 0) begin
				level_long = 8'($urandom_range(20, 80));
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 30) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(5, 30)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
				if (green_out !== want.green)
					report_mismatch("green_out", green_out, want.green);
				if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
				if (inside_res !== want.in_frame)
					report_mismatch("inside_res", inside_res, want.in_frame);
				if (want.in_frame) n_inside++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = 1'b0;
		col = '0;
		row = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		cfg_width = 7'd64;
		cfg_height = 7'd64;
		cfg_cos = 8'd64;
		cfg_sin = 8'd0;
		for (int i = 0; i < FRAME_DIM * FRAME_DIM; i++) begin
			frame_copy[i] = '0;
			frame_loaded[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_frame();
		test_directed();
		test_hold_off();
		test_random_settings();
		wait_drained();
		$display("covered %0d loads, %0d renders (%0d inside), %0d register writes",
			n_loads, n_renders, n_inside, n_configs);
		if (expected_pixels.size() != 0) n_errors++;
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
design/imr_pkg.sv
design/imr_front.sv
design/imr_queue.sv
design/imr_back.sv
design/inverse_map_rgb_rotator_unit.sv
tb/tb_top.sv
